FILE: src/kruskal_pkg.sv
package kruskal_pkg;

    // payload widths of the two channels
    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 32;
    localparam int TOTAL_W  = 64;
    localparam int COUNT_W  = 10;

    // command codes
    localparam logic CMD_EDGE  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

endpackage

FILE: src/kruskal_union_find_edge_filter.sv
// Kruskal edge filter over a union-find forest held in one on-chip memory.
// Input channel s_*: one word per edge (sorted by ascending weight) or a clear
// command. Output channel m_*: exactly one result word per input word, giving
// whether the edge was taken, the running 64-bit total, the taken count and an
// echo of final_edge.
// Each edge is a sequence of memory steps: a root walk and a compression
// walk for node_a, the same for node_b, then, for a taken edge, the link
// write and the size write of the union. The walks run one memory step
// after another because the node memory has a single read port. An edge
// with an endpoint out of range goes to its result without any walk.
// A clear command rewrites every memory entry.
// After reset the same clearing pass runs with s_ready low; no result is
// produced for it.
// Results wait in an output register: the next word is accepted while a result
// is still held, and the block stalls only when a second result is ready
// before the first one is taken.
module kruskal_union_find_edge_filter
    import kruskal_pkg::*;
#(
    parameter int NODE_COUNT = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_command,
    input  logic [NODE_W-1:0]          s_node_a,
    input  logic [NODE_W-1:0]          s_node_b,
    input  logic signed [WEIGHT_W-1:0] s_edge_weight,
    input  logic                       s_final_edge,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_edge_taken,
    output logic signed [TOTAL_W-1:0]  m_running_total,
    output logic [COUNT_W-1:0]         m_taken_count,
    output logic                       m_tree_done
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SW = $clog2(NODE_COUNT + 1);

    typedef struct packed {
        logic [AW-1:0] parent;
        logic [SW-1:0] size;
    } node_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_A,
        ST_COMP_A,
        ST_FIND_B,
        ST_COMP_B,
        ST_UNION,
        ST_DONE
    } state_t;

    state_t                      state_reg;
    logic [AW-1:0]               node_a_reg;
    logic [AW-1:0]               node_b_reg;
    logic signed [WEIGHT_W-1:0]  weight_reg;
    logic                        final_reg;
    logic [AW-1:0]               walk_reg;
    logic [AW-1:0]               root_a_reg;
    logic [AW-1:0]               root_b_reg;
    logic [SW-1:0]               size_a_reg;
    logic [SW-1:0]               size_b_reg;
    logic                        taken_reg;
    logic [AW-1:0]               clr_addr_reg;
    logic                        clr_result_reg;
    logic signed [TOTAL_W-1:0]   cost_sum_reg;
    logic [COUNT_W-1:0]          edges_taken_reg;
    logic                        m_valid_reg;
    logic                        m_edge_taken_reg;
    logic signed [TOTAL_W-1:0]   m_running_total_reg;
    logic [COUNT_W-1:0]          m_taken_count_reg;
    logic                        m_tree_done_reg;

    node_word_t                  node_mem [NODE_COUNT];
    node_word_t                  rd_data_reg;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    node_word_t                  wr_data;

    logic                        root_hit;
    logic                        a_smaller;
    logic [AW-1:0]               big_root;
    logic [AW-1:0]               small_root;
    logic                        in_range;
    logic                        s_accept;

    // node memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= node_mem[rd_addr];
    end

    // helper terms
    assign root_hit   = (rd_data_reg.parent == walk_reg);
    assign a_smaller  = (size_a_reg < size_b_reg);
    assign big_root   = a_smaller ? root_b_reg : root_a_reg;
    assign small_root = a_smaller ? root_a_reg : root_b_reg;
    assign in_range   = (int'(s_node_a) < NODE_COUNT) && (int'(s_node_b) < NODE_COUNT);
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;

    // memory address and write selection per step
    always_comb begin
        rd_addr = walk_reg;
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '{parent: clr_addr_reg, size: SW'(1)};
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
            end
            ST_IDLE: begin
                rd_addr = AW'(s_node_a);
            end
            ST_FIND_A: begin
                rd_addr = root_hit ? node_a_reg : rd_data_reg.parent;
            end
            ST_COMP_A: begin
                if (walk_reg == root_a_reg) begin
                    rd_addr = node_b_reg;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = walk_reg;
                    wr_data = '{parent: root_a_reg, size: rd_data_reg.size};
                    rd_addr = rd_data_reg.parent;
                end
            end
            ST_FIND_B: begin
                rd_addr = root_hit ? node_b_reg : rd_data_reg.parent;
            end
            ST_COMP_B: begin
                if (walk_reg == root_b_reg) begin
                    // link the smaller root under the larger one
                    if (root_a_reg != root_b_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = small_root;
                        wr_data = '{parent: big_root, size: SW'(1)};
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = walk_reg;
                    wr_data = '{parent: root_b_reg, size: rd_data_reg.size};
                    rd_addr = rd_data_reg.parent;
                end
            end
            ST_UNION: begin
                wr_en   = 1'b1;
                wr_addr = big_root;
                wr_data = '{parent: big_root, size: SW'(size_a_reg + size_b_reg)};
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // sequencer, running state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            clr_result_reg  <= 1'b0;
            cost_sum_reg    <= '0;
            edges_taken_reg <= '0;
            m_valid_reg     <= 1'b0;
            taken_reg       <= 1'b0;
            final_reg       <= 1'b0;
        end else begin
            // result taken; the done step reloads the register itself
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (clr_addr_reg == AW'(NODE_COUNT - 1)) begin
                        clr_addr_reg   <= '0;
                        clr_result_reg <= 1'b0;
                        state_reg      <= clr_result_reg ? ST_DONE : ST_IDLE;
                    end else begin
                        clr_addr_reg <= clr_addr_reg + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        node_a_reg <= AW'(s_node_a);
                        node_b_reg <= AW'(s_node_b);
                        weight_reg <= s_edge_weight;
                        walk_reg   <= AW'(s_node_a);
                        taken_reg  <= 1'b0;
                        if (s_command == CMD_CLEAR) begin
                            cost_sum_reg    <= '0;
                            edges_taken_reg <= '0;
                            final_reg       <= 1'b0;
                            clr_addr_reg    <= '0;
                            clr_result_reg  <= 1'b1;
                            state_reg       <= ST_CLEAR;
                        end else begin
                            final_reg <= s_final_edge;
                            if (in_range) begin
                                state_reg <= ST_FIND_A;
                            end else begin
                                state_reg <= ST_DONE;
                            end
                        end
                    end
                end
                ST_FIND_A: begin
                    if (root_hit) begin
                        root_a_reg <= walk_reg;
                        size_a_reg <= rd_data_reg.size;
                        walk_reg   <= node_a_reg;
                        state_reg  <= ST_COMP_A;
                    end else begin
                        walk_reg <= rd_data_reg.parent;
                    end
                end
                ST_COMP_A: begin
                    if (walk_reg == root_a_reg) begin
                        walk_reg  <= node_b_reg;
                        state_reg <= ST_FIND_B;
                    end else begin
                        walk_reg <= rd_data_reg.parent;
                    end
                end
                ST_FIND_B: begin
                    if (root_hit) begin
                        root_b_reg <= walk_reg;
                        size_b_reg <= rd_data_reg.size;
                        walk_reg   <= node_b_reg;
                        state_reg  <= ST_COMP_B;
                    end else begin
                        walk_reg <= rd_data_reg.parent;
                    end
                end
                ST_COMP_B: begin
                    if (walk_reg == root_b_reg) begin
                        state_reg <= (root_a_reg != root_b_reg) ? ST_UNION : ST_DONE;
                    end else begin
                        walk_reg <= rd_data_reg.parent;
                    end
                end
                ST_UNION: begin
                    cost_sum_reg    <= cost_sum_reg
                                       + {{(TOTAL_W - WEIGHT_W){weight_reg[WEIGHT_W-1]}},
                                          weight_reg};
                    edges_taken_reg <= edges_taken_reg + COUNT_W'(1);
                    taken_reg       <= 1'b1;
                    state_reg       <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg         <= 1'b1;
                        m_edge_taken_reg    <= taken_reg;
                        m_running_total_reg <= cost_sum_reg;
                        m_taken_count_reg   <= edges_taken_reg;
                        m_tree_done_reg     <= final_reg;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_edge_taken    = m_edge_taken_reg;
    assign m_running_total = m_running_total_reg;
    assign m_taken_count   = m_taken_count_reg;
    assign m_tree_done     = m_tree_done_reg;

    // compression never reads the entry it rewrites in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (((state_reg == ST_COMP_A) && (walk_reg != root_a_reg))
            || ((state_reg == ST_COMP_B) && (walk_reg != root_b_reg)))
            |-> (wr_addr != rd_addr))
        else $error("compression read and write hit the same entry");

    // the total moves only on a union or a clear command
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg != ST_UNION) && !s_accept) |=> $stable(cost_sum_reg))
        else $error("running total changed without a taken edge");

    // a taken edge always reports a non-zero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_edge_taken) |-> (m_taken_count != '0))
        else $error("taken edge with zero count");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import kruskal_pkg::*;

    localparam int NODES       = 1024;
    localparam int N_WORDS     = 1600;
    localparam int IDLE_PCT    = 18;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_FROM   = 600;
    localparam int CALM_TO     = 900;
    localparam int TAIL_CYCLES = 60;
    localparam int MAX_PRINTS  = 40;
    localparam int POOL_MAX    = 160;

    localparam logic signed [WEIGHT_W-1:0] W_MIN = 32'sh8000_0000;
    localparam logic signed [WEIGHT_W-1:0] W_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic                       command;
        logic [NODE_W-1:0]          node_a;
        logic [NODE_W-1:0]          node_b;
        logic signed [WEIGHT_W-1:0] edge_weight;
        logic                       final_edge;
        bit                         drain_first;
    } edge_word_t;

    typedef struct {
        logic                      taken;
        logic signed [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0]        count;
        logic                      done;
    } edge_result_t;

    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic                       s_command       = CMD_EDGE;
    logic [NODE_W-1:0]          s_node_a        = '0;
    logic [NODE_W-1:0]          s_node_b        = '0;
    logic signed [WEIGHT_W-1:0] s_edge_weight   = '0;
    logic                       s_final_edge    = 1'b0;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic                       m_edge_taken;
    logic signed [TOTAL_W-1:0]  m_running_total;
    logic [COUNT_W-1:0]         m_taken_count;
    logic                       m_tree_done;

    // predicted forest and tree totals
    logic [NODE_W-1:0]         forest_parent [NODES];
    logic [NODE_W:0]           forest_size   [NODES];
    logic signed [TOTAL_W-1:0] tree_cost;
    logic [COUNT_W-1:0]        tree_edges;

    edge_word_t   pending_words[$];
    edge_result_t expected_results[$];

    int          n_words        = 0;
    int          n_accepted     = 0;
    int          results_seen   = 0;
    int          mismatch_count = 0;
    longint      cycle_count    = 0;
    longint      cycle_limit    = 64'h7FFF_FFFF_FFFF_FFFF;
    logic        s_fire         = 1'b0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;

    kruskal_union_find_edge_filter #(
        .NODE_COUNT(NODES)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_node_a       (s_node_a),
        .s_node_b       (s_node_b),
        .s_edge_weight  (s_edge_weight),
        .s_final_edge   (s_final_edge),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_edge_taken   (m_edge_taken),
        .m_running_total(m_running_total),
        .m_taken_count  (m_taken_count),
        .m_tree_done    (m_tree_done)
    );

    // clock
    always #5 aclk = ~aclk;

    // forest back to singletons, totals to zero
    function automatic void clear_forest();
        for (int n = 0; n < NODES; n++) begin
            forest_parent[n] = NODE_W'(n);
            forest_size[n]   = (NODE_W + 1)'(1);
        end
        tree_cost  = '0;
        tree_edges = '0;
    endfunction

    // root lookup with the path relinked straight to the root
    function automatic logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] v);
        logic [NODE_W-1:0] r;
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] nxt;
        r = v;
        while (forest_parent[r] != r)
            r = forest_parent[r];
        cur = v;
        while (cur != r) begin
            nxt                = forest_parent[cur];
            forest_parent[cur] = r;
            cur                = nxt;
        end
        return r;
    endfunction

    // one word through the forest, giving the result it should produce
    function automatic edge_result_t apply_word(edge_word_t w);
        edge_result_t      res;
        logic [NODE_W-1:0] root_a;
        logic [NODE_W-1:0] root_b;
        logic [NODE_W-1:0] major_root;
        logic [NODE_W-1:0] minor_root;
        res.taken = 1'b0;
        res.total = '0;
        res.count = '0;
        res.done  = 1'b0;
        if (w.command == CMD_CLEAR) begin
            clear_forest();
            return res;
        end
        if (w.node_a < NODES && w.node_b < NODES) begin
            root_a = find_root(w.node_a);
            root_b = find_root(w.node_b);
            if (root_a != root_b) begin
                // larger set keeps its root, node_a's root wins a tie
                major_root = root_a;
                minor_root = root_b;
                if (forest_size[root_a] < forest_size[root_b]) begin
                    major_root = root_b;
                    minor_root = root_a;
                end
                forest_parent[minor_root] = major_root;
                forest_size[major_root]   = forest_size[major_root] + forest_size[minor_root];
                tree_cost  = tree_cost
                           + {{(TOTAL_W-WEIGHT_W){w.edge_weight[WEIGHT_W-1]}}, w.edge_weight};
                tree_edges = tree_edges + 1'b1;
                res.taken  = 1'b1;
            end
        end
        res.total = tree_cost;
        res.count = tree_edges;
        res.done  = w.final_edge;
        return res;
    endfunction

    task automatic add_word(logic cmd, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                            logic signed [WEIGHT_W-1:0] w, logic fin, bit drain = 1'b0);
        edge_word_t word;
        word.command     = cmd;
        word.node_a      = a;
        word.node_b      = b;
        word.edge_weight = w;
        word.final_edge  = fin;
        word.drain_first = drain;
        pending_words    = {pending_words, word};
    endtask

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // cycle counter and timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result check first, then prediction of the word accepted at this edge
    always @(posedge aclk) begin : watch_channels
        edge_result_t want;
        edge_word_t   got_word;
        s_fire <= s_valid && s_ready;
        if (m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (m_edge_taken !== want.taken)
                    report_mismatch($sformatf("edge_taken got %b want %b",
                                              m_edge_taken, want.taken));
                if (m_running_total !== want.total)
                    report_mismatch($sformatf("running_total got %0d want %0d",
                                              m_running_total, want.total));
                if (m_taken_count !== want.count)
                    report_mismatch($sformatf("taken_count got %0d want %0d",
                                              m_taken_count, want.count));
                if (m_tree_done !== want.done)
                    report_mismatch($sformatf("tree_done got %b want %b",
                                              m_tree_done, want.done));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            got_word.command     = s_command;
            got_word.node_a      = s_node_a;
            got_word.node_b      = s_node_b;
            got_word.edge_weight = s_edge_weight;
            got_word.final_edge  = s_final_edge;
            got_word.drain_first = 1'b0;
            expected_results     = {expected_results, apply_word(got_word)};
            n_accepted <= n_accepted + 1;
        end
    end

    // input driver, one word from the pending queue at a time
    always @(negedge aclk) begin : drive_words
        edge_word_t word_out;
        bit         calm;
        calm = n_accepted >= CALM_FROM && n_accepted < CALM_TO;
        if (aresetn && (!s_valid || s_fire)) begin
            if (pending_words.size() != 0
                && !(pending_words[0].drain_first && expected_results.size() != 0)
                && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                word_out      = pending_words.pop_front();
                s_command     <= word_out.command;
                s_node_a      <= word_out.node_a;
                s_node_b      <= word_out.node_b;
                s_edge_weight <= word_out.edge_weight;
                s_final_edge  <= word_out.final_edge;
                s_valid       <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off while the sender keeps going
    always @(negedge aclk) begin
        if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver ready with random stalls
    always @(negedge aclk) begin
        if (!aresetn || hold_left != 0)
            m_ready <= 1'b0;
        else if (results_seen >= CALM_FROM && results_seen < CALM_TO)
            m_ready <= 1'b1;
        else
            m_ready <= $urandom_range(0, 99) >= IDLE_PCT;
    end

    // stimulus, reset and end of run
    initial begin
        logic [NODE_W-1:0] node_pool [POOL_MAX];
        logic [NODE_W-1:0] pick_a;
        logic [NODE_W-1:0] pick_b;
        int                graph_nodes;
        int                n_edges;
        longint            wt;
        longint            budget;
        bit                first_random;

        clear_forest();

        // directed: extreme weights and nodes, loops, ties, clear
        add_word(CMD_EDGE, 10'd0, 10'd1023, W_MIN, 1'b0);
        add_word(CMD_EDGE, 10'd1023, 10'd0, W_MIN, 1'b0);
        add_word(CMD_EDGE, 10'd5, 10'd5, -32'sd1, 1'b0);
        add_word(CMD_EDGE, 10'd1, 10'd2, 32'sd0, 1'b0);
        add_word(CMD_EDGE, 10'd2, 10'd1, 32'sd3, 1'b0);
        add_word(CMD_EDGE, 10'd3, 10'd4, 32'sd7, 1'b0);
        add_word(CMD_EDGE, 10'd1, 10'd3, 32'sd100, 1'b0);
        add_word(CMD_EDGE, 10'd0, 10'd4, 32'sd1000, 1'b0);
        add_word(CMD_EDGE, 10'd1023, 10'd5, W_MAX, 1'b0);
        add_word(CMD_EDGE, 10'h2AA, 10'h155, W_MAX, 1'b1);
        add_word(CMD_CLEAR, 10'd1023, 10'd1023, -32'sd1, 1'b1);
        add_word(CMD_EDGE, 10'd1023, 10'd0, W_MAX, 1'b0);
        // deeper trees, then a lookup through them
        add_word(CMD_EDGE, 10'd10, 10'd11, 32'sd1, 1'b0);
        add_word(CMD_EDGE, 10'd12, 10'd13, 32'sd2, 1'b0);
        add_word(CMD_EDGE, 10'd11, 10'd13, 32'sd3, 1'b0);
        add_word(CMD_EDGE, 10'd14, 10'd15, 32'sd4, 1'b0);
        add_word(CMD_EDGE, 10'd16, 10'd17, 32'sd5, 1'b0);
        add_word(CMD_EDGE, 10'd15, 10'd17, 32'sd6, 1'b0);
        add_word(CMD_EDGE, 10'd13, 10'd17, 32'sd7, 1'b0);
        add_word(CMD_EDGE, 10'd10, 10'd16, 32'sd8, 1'b0);
        add_word(CMD_EDGE, 10'd1022, 10'd10, 32'sd9, 1'b0);
        add_word(CMD_EDGE, 10'd1023, 10'd17, 32'sd10, 1'b1);
        add_word(CMD_CLEAR, 10'd0, 10'd0, 32'sd0, 1'b0);

        // random: mostly sorted graphs after a clear, some loose words
        first_random = 1'b1;
        while (pending_words.size() < N_WORDS) begin
            if ($urandom_range(0, 99) < 85) begin
                graph_nodes = ($urandom_range(0, 7) == 0) ? $urandom_range(25, POOL_MAX)
                                                           : $urandom_range(2, 24);
                for (int k = 0; k < graph_nodes; k++)
                    node_pool[k] = NODE_W'($urandom_range(0, NODES - 1));
                n_edges = $urandom_range(graph_nodes - 1, 2 * graph_nodes);
                add_word(CMD_CLEAR, NODE_W'($urandom), NODE_W'($urandom), $urandom,
                         1'($urandom_range(0, 1)), first_random);
                first_random = 1'b0;
                if ($urandom_range(0, 3) == 0)
                    wt = longint'(W_MIN) + $urandom_range(0, 1000);
                else
                    wt = longint'($signed($urandom));
                for (int e = 0; e < n_edges; e++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        pick_a = node_pool[e % graph_nodes];
                        pick_b = node_pool[(e + 1) % graph_nodes];
                    end else begin
                        pick_a = node_pool[$urandom_range(0, graph_nodes - 1)];
                        pick_b = node_pool[$urandom_range(0, graph_nodes - 1)];
                    end
                    wt = wt + $urandom_range(0, 1 << 24);
                    if (wt > longint'(W_MAX))
                        wt = longint'(W_MAX);
                    add_word(CMD_EDGE, pick_a, pick_b, wt[WEIGHT_W-1:0],
                             e == n_edges - 1);
                end
            end else begin
                add_word(($urandom_range(0, 9) == 0) ? CMD_CLEAR : CMD_EDGE,
                         NODE_W'($urandom), NODE_W'($urandom), $urandom,
                         1'($urandom_range(0, 1)));
            end
        end
        n_words = pending_words.size();

        // timeout from the slowest run: clears, deepest finds, gaps and stalls
        budget = NODES + HOLD_CYCLES;
        foreach (pending_words[i])
            budget += ((pending_words[i].command == CMD_CLEAR) ? NODES + 3 : 64) + 32;
        cycle_limit = 4 * budget + 10000;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_words || expected_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/kruskal_pkg.sv
src/kruskal_union_find_edge_filter.sv
tb/tb.sv
